@@ src/fpha_pkg.sv @@
package fpha_pkg;

   localparam int MAX_GRANTS = 16;
   localparam int MAX_HOLES  = 17;
   localparam int ADDR_BITS  = 16;
   localparam int LEN_BITS   = ADDR_BITS + 1;
   localparam int GIDX_BITS  = $clog2(MAX_GRANTS);
   localparam int HIDX_BITS  = $clog2(MAX_HOLES);
   localparam int HCNT_BITS  = $clog2(MAX_HOLES + 1);
   localparam int GCNT_BITS  = $clog2(MAX_GRANTS + 1);
   localparam int ALIGN      = 4;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NO_FIT   = 2'd1;
   localparam logic [1:0] ST_NO_FOUND = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   localparam logic [1:0] FIT_FIRST = 2'd0;
   localparam logic [1:0] FIT_BEST  = 2'd1;
   localparam logic [1:0] FIT_WORST = 2'd2;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic CSR_FIT_MODE = 1'b0;
   localparam logic CSR_TOTAL    = 1'b1;

   // controller -> datapath commands
   typedef struct packed {
      logic load;       // capture request
      logic init;       // reinitialize region
      logic gscan;      // examine grant entry at scan index
      logic hscan;      // examine hole entry at scan index
      logic scan_clr;   // zero scan index
      logic alloc_do;   // commit allocation
      logic free_do;    // commit free (merge decision)
      logic shl;        // shift hole table left one step
      logic shr;        // shift hole table right one step
      logic finish;     // latch result
   } cmd_type;

   // datapath -> controller status
   typedef struct packed {
      logic is_free;
      logic gscan_last;
      logic hscan_last;
      logic slot_found;
      logic grant_match;
      logic hole_found;
      logic need_drop;   // drop/merge needs left shift
      logic need_ins;    // insert needs right shift
      logic holes_full;
      logic shift_done;
   } sts_type;

endpackage

@@ src/fpha_ctrl.sv @@
module fpha_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output fpha_pkg::cmd_type cmd,
   input  fpha_pkg::sts_type sts,
   output logic [1:0]       status_out
);
   import fpha_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_GSCAN = 7'b0000010,
      S_HSCAN = 7'b0000100,
      S_COMMIT= 7'b0001000,
      S_SHL   = 7'b0010000,
      S_SHR   = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   state_type  state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] status_ff, status_in;

   assign req_stall  = (state_ff != S_IDLE) || rsp_valid_ff;
   assign rsp_valid  = rsp_valid_ff;
   assign status_out = status_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      status_in    = status_ff;
      cmd          = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && !req_stall) begin
               cmd.load     = 1'b1;
               cmd.scan_clr = 1'b1;
               state_in     = S_GSCAN;
            end
         end
         S_GSCAN: begin
            cmd.gscan = 1'b1;
            if (sts.gscan_last) begin
               cmd.scan_clr = 1'b1;
               state_in     = S_HSCAN;
            end
         end
         S_HSCAN: begin
            cmd.hscan = 1'b1;
            if (sts.hscan_last) state_in = S_COMMIT;
         end
         S_COMMIT: begin
            state_in = S_DONE;
            if (!sts.is_free) begin
               if (!sts.slot_found) status_in = ST_FULL;
               else if (!sts.hole_found) status_in = ST_NO_FIT;
               else begin
                  status_in     = ST_OK;
                  cmd.alloc_do  = 1'b1;
                  cmd.scan_clr  = 1'b1;
                  if (sts.need_drop) state_in = S_SHL;
               end
            end else begin
               if (!sts.grant_match) status_in = ST_NO_FOUND;
               else if (sts.need_ins && sts.holes_full) status_in = ST_FULL;
               else begin
                  status_in    = ST_OK;
                  cmd.free_do  = 1'b1;
                  cmd.scan_clr = 1'b1;
                  if (sts.need_drop) state_in = S_SHL;
                  else if (sts.need_ins) state_in = S_SHR;
               end
            end
         end
         S_SHL: begin
            cmd.shl = 1'b1;
            if (sts.shift_done) state_in = S_DONE;
         end
         S_SHR: begin
            cmd.shr = 1'b1;
            if (sts.shift_done) state_in = S_DONE;
         end
         S_DONE: begin
            cmd.finish   = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff <= status_in;
   end
endmodule

@@ src/fpha_dp.sv @@
module fpha_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  fpha_pkg::cmd_type           cmd,
   output fpha_pkg::sts_type           sts,
   input  logic [1:0]                  fit_mode,
   input  logic [15:0]                 total_bytes,
   input  logic                        operation,
   input  logic [15:0]                 request_size,
   input  logic [15:0]                 block_address,
   input  logic [7:0]                  owner_id,
   input  logic [1:0]                  status,
   output logic [15:0]                 granted_address,
   output logic [15:0]                 free_bytes,
   output logic [15:0]                 used_bytes
);
   import fpha_pkg::*;

   logic [ADDR_BITS-1:0] hbase_ff [MAX_HOLES];
   logic [LEN_BITS-1:0]  hlen_ff  [MAX_HOLES];
   logic [HCNT_BITS-1:0] hcnt_ff;
   logic [ADDR_BITS-1:0] gbase_ff [MAX_GRANTS];
   logic [LEN_BITS-1:0]  glen_ff  [MAX_GRANTS];
   logic [7:0]           gown_ff  [MAX_GRANTS];
   logic [MAX_GRANTS-1:0] gval_ff;
   logic [LEN_BITS-1:0]  ftot_ff;

   logic                 op_ff;
   logic [LEN_BITS-1:0]  need_ff;
   logic [ADDR_BITS-1:0] addr_ff;
   logic [7:0]           own_ff;
   logic [GCNT_BITS-1:0] gidx_ff;
   logic [HCNT_BITS-1:0] hidx_ff;
   logic                 slot_ok_ff, match_ff, hfound_ff;
   logic [GIDX_BITS-1:0] slot_ff, gmatch_ff;
   logic [HIDX_BITS-1:0] pick_ff;
   logic [LEN_BITS-1:0]  glen_sel_ff;
   logic [HCNT_BITS-1:0] pos_ff;        // first hole with base > addr
   logic [HCNT_BITS-1:0] sh_ff, shend_ff;
   logic [ADDR_BITS-1:0] gaddr_ff;

   logic [GIDX_BITS-1:0] gi;
   logic [HIDX_BITS-1:0] hi;
   logic [LEN_BITS-1:0]  cur_len;
   logic [ADDR_BITS-1:0] cur_base;
   logic                 fits, better;
   logic [LEN_BITS-1:0]  need_c;
   logic [HIDX_BITS-1:0] pos_i, posm1;
   logic                 jp, jn;
   logic [LEN_BITS-1:0]  prev_end, new_end;

   assign gi       = gidx_ff[GIDX_BITS-1:0];
   assign hi       = hidx_ff[HIDX_BITS-1:0];
   assign cur_len  = hlen_ff[hi];
   assign cur_base = hbase_ff[hi];
   assign fits     = cur_len >= need_ff;
   always_comb begin
      if (fit_mode == FIT_BEST)       better = cur_len < hlen_ff[pick_ff];
      else if (fit_mode == FIT_WORST) better = cur_len > hlen_ff[pick_ff];
      else                            better = 1'b0;
   end

   always_comb begin
      need_c = ({1'b0, request_size} + LEN_BITS'(ALIGN - 1)) & ~LEN_BITS'(ALIGN - 1);
      if (need_c == '0) need_c = LEN_BITS'(ALIGN);
   end

   assign pos_i    = pos_ff[HIDX_BITS-1:0];
   assign posm1    = pos_i - 1'b1;
   assign prev_end = {1'b0, hbase_ff[posm1]} + hlen_ff[posm1];
   assign new_end  = {1'b0, addr_ff} + glen_sel_ff;
   assign jp = (pos_ff != '0) && (prev_end == {1'b0, addr_ff});
   assign jn = (pos_ff < hcnt_ff) && (new_end == {1'b0, hbase_ff[pos_i]});

   // a dropped last entry needs no shift
   always_comb begin
      sts             = '0;
      sts.is_free     = op_ff;
      sts.gscan_last  = gidx_ff == GCNT_BITS'(MAX_GRANTS - 1);
      sts.hscan_last  = hidx_ff == HCNT_BITS'(MAX_HOLES - 1);
      sts.slot_found  = slot_ok_ff;
      sts.grant_match = match_ff;
      sts.hole_found  = hfound_ff;
      sts.holes_full  = hcnt_ff >= HCNT_BITS'(MAX_HOLES);
      sts.need_ins    = !jp && !jn;
      if (op_ff) sts.need_drop = jp && jn && (pos_ff != hcnt_ff - 1'b1);
      else       sts.need_drop = (hlen_ff[pick_ff] == need_ff)
                                 && (HCNT_BITS'(pick_ff) != hcnt_ff - 1'b1);
      sts.shift_done  = sh_ff == shend_ff;
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.init) begin
         hbase_ff[0] <= '0;
         hlen_ff[0]  <= {1'b0, total_bytes};
         hcnt_ff     <= HCNT_BITS'(1);
         gval_ff     <= '0;
         ftot_ff     <= {1'b0, total_bytes};
      end else begin
         if (cmd.alloc_do) begin
            gval_ff[slot_ff] <= 1'b1;
            gbase_ff[slot_ff] <= hbase_ff[pick_ff];
            glen_ff[slot_ff]  <= need_ff;
            gown_ff[slot_ff]  <= own_ff;
            ftot_ff <= ftot_ff - need_ff;
            if (hlen_ff[pick_ff] == need_ff) begin
               hcnt_ff <= hcnt_ff - 1'b1;
            end else begin
               hbase_ff[pick_ff] <= hbase_ff[pick_ff] + need_ff[ADDR_BITS-1:0];
               hlen_ff[pick_ff]  <= hlen_ff[pick_ff] - need_ff;
            end
         end
         if (cmd.free_do) begin
            gval_ff[gmatch_ff] <= 1'b0;
            ftot_ff <= ftot_ff + glen_sel_ff;
            if (jp) begin
               if (jn) begin
                  hlen_ff[posm1] <= hlen_ff[posm1] + glen_sel_ff + hlen_ff[pos_i];
                  hcnt_ff <= hcnt_ff - 1'b1;
               end else hlen_ff[posm1] <= hlen_ff[posm1] + glen_sel_ff;
            end else if (jn) begin
               hbase_ff[pos_i] <= addr_ff;
               hlen_ff[pos_i]  <= hlen_ff[pos_i] + glen_sel_ff;
            end else begin
               hcnt_ff <= hcnt_ff + 1'b1;
            end
         end
         if (cmd.shl) begin
            hbase_ff[sh_ff[HIDX_BITS-1:0]] <= hbase_ff[sh_ff[HIDX_BITS-1:0] + 1'b1];
            hlen_ff[sh_ff[HIDX_BITS-1:0]]  <= hlen_ff[sh_ff[HIDX_BITS-1:0] + 1'b1];
         end
         if (cmd.shr) begin
            if (sh_ff == shend_ff) begin
               hbase_ff[sh_ff[HIDX_BITS-1:0]] <= addr_ff;
               hlen_ff[sh_ff[HIDX_BITS-1:0]]  <= glen_sel_ff;
            end else begin
               hbase_ff[sh_ff[HIDX_BITS-1:0]] <= hbase_ff[sh_ff[HIDX_BITS-1:0] - 1'b1];
               hlen_ff[sh_ff[HIDX_BITS-1:0]]  <= hlen_ff[sh_ff[HIDX_BITS-1:0] - 1'b1];
            end
         end
      end
   end

   // request capture, scan and shift sequencing, result latch
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff      <= operation;
         need_ff    <= need_c;
         addr_ff    <= block_address;
         own_ff     <= owner_id;
         slot_ok_ff <= 1'b0;
         match_ff   <= 1'b0;
         hfound_ff  <= 1'b0;
         pos_ff     <= '0;
         pick_ff    <= '0;
      end
      if (cmd.scan_clr) begin
         gidx_ff <= '0;
         hidx_ff <= '0;
      end else begin
         if (cmd.gscan) gidx_ff <= gidx_ff + 1'b1;
         if (cmd.hscan) hidx_ff <= hidx_ff + 1'b1;
      end
      if (cmd.gscan) begin
         if (!gval_ff[gi] && !slot_ok_ff) begin
            slot_ok_ff <= 1'b1;
            slot_ff    <= gi;
         end
         if (gval_ff[gi] && gbase_ff[gi] == addr_ff && gown_ff[gi] == own_ff
             && !match_ff) begin
            match_ff    <= 1'b1;
            gmatch_ff   <= gi;
            glen_sel_ff <= glen_ff[gi];
         end
      end
      if (cmd.hscan && hidx_ff < hcnt_ff) begin
         if (fits && (!hfound_ff || better)) begin
            hfound_ff <= 1'b1;
            pick_ff   <= hi;
         end
         if (cur_base <= addr_ff && pos_ff == hidx_ff) pos_ff <= hidx_ff + 1'b1;
      end
      if (cmd.alloc_do) begin
         sh_ff    <= HCNT_BITS'(pick_ff);
         shend_ff <= hcnt_ff - HCNT_BITS'(2);
         gaddr_ff <= hbase_ff[pick_ff];
      end
      if (cmd.free_do) begin
         if (jp && jn) begin
            sh_ff    <= pos_ff;
            shend_ff <= hcnt_ff - HCNT_BITS'(2);
         end else begin
            sh_ff    <= hcnt_ff;
            shend_ff <= pos_ff;
         end
         gaddr_ff <= '0;
      end
      if (cmd.shl && sh_ff != shend_ff) sh_ff <= sh_ff + 1'b1;
      if (cmd.shr && sh_ff != shend_ff) sh_ff <= sh_ff - 1'b1;
      if (cmd.finish) begin
         granted_address <= (status == ST_OK && !op_ff) ? gaddr_ff : '0;
         free_bytes      <= ftot_ff[15:0];
         used_bytes      <= total_bytes - ftot_ff[15:0];
      end
   end
endmodule

@@ src/fit_policy_heap_allocator.sv @@
// Sequence: request accept, 16-entry grant scan, 17-entry hole scan, commit,
//   optional hole-table shift steps, then the result on rsp_valid.
// Throughput: one transaction at a time; the next is taken only when idle
//   and the result register is empty, so rsp_stall holds off new requests.
// Reset: synchronous, active high; one hole spans 16384 bytes, no grants.
module fit_policy_heap_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [15:0] req_request_size,
   input  logic [15:0] req_block_address,
   input  logic [7:0]  req_owner_id,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_granted_address,
   output logic [15:0] rsp_free_bytes,
   output logic [15:0] rsp_used_bytes,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);
   import fpha_pkg::*;

   logic [1:0]  fit_mode_ff;
   logic [15:0] total_ff;
   cmd_type     cmd, dp_cmd;
   sts_type     sts;
   logic        init_w;

   // the user must write config only while idle; the block itself does not enforce it
   assign csr_ready = 1'b1;
   assign init_w    = csr_valid && csr_index == CSR_TOTAL;

   always_ff @(posedge clock) begin
      if (reset) begin
         fit_mode_ff <= FIT_FIRST;
         total_ff    <= 16'd16384;
      end else if (csr_valid) begin
         if (csr_index == CSR_FIT_MODE) fit_mode_ff <= csr_data[1:0];
         else total_ff <= (csr_data < 16'd4) ? 16'd4 : csr_data;
      end
   end

   // reinit in the cycle after the write so it sees the new size
   logic init_ff;
   always_ff @(posedge clock) begin
      if (reset) init_ff <= 1'b0;
      else       init_ff <= init_w;
   end

   always_comb begin
      dp_cmd      = cmd;
      dp_cmd.init = init_ff;
   end

   fpha_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .cmd, .sts, .status_out(rsp_status)
   );

   fpha_dp u_dp (
      .clock, .reset, .cmd(dp_cmd), .sts,
      .fit_mode(fit_mode_ff), .total_bytes(total_ff),
      .operation(req_operation), .request_size(req_request_size),
      .block_address(req_block_address), .owner_id(req_owner_id),
      .status(rsp_status),
      .granted_address(rsp_granted_address),
      .free_bytes(rsp_free_bytes), .used_bytes(rsp_used_bytes)
   );

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("accept while result pending");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid) else $error("result dropped");
   a_grant_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_granted_address == 16'd0)
      else $error("address on failed transaction");
endmodule

@@ test/fit_policy_heap_allocator_tb.sv @@
`timescale 1ns / 100ps

module fit_policy_heap_allocator_tb;
   import fpha_pkg::*;

   localparam int HALF_PERIOD = 6;
   localparam int SETTLE_CYCLES = 80;
   localparam int LONG_HOLD = 400;       // receiver hold-off, in cycles
   localparam int PHASE_ITEMS = 300;

   // one request transaction as driven on the req_ ports
   typedef struct {
      logic        op;
      logic [15:0] size;
      logic [15:0] addr;
      logic [7:0]  owner;
   } heap_req_type;

   // one response transaction as seen on the rsp_ ports
   typedef struct {
      logic [1:0]  status;
      logic [15:0] granted;
      logic [15:0] free_b;
      logic [15:0] used_b;
   } heap_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_operation = OP_ALLOC;
   logic [15:0] req_request_size = '0;
   logic [15:0] req_block_address = '0;
   logic [7:0]  req_owner_id = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_granted_address;
   logic [15:0] rsp_free_bytes;
   logic [15:0] rsp_used_bytes;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = CSR_FIT_MODE;
   logic [15:0] csr_data = '0;

   heap_req_type pending_reqs[$];
   heap_rsp_type expected_rsps[$];
   int        mismatches = 0;
   int        hold_requests = 0;    // bumped by the stimulus process
   int        hold_served = 0;      // owned by the receiver process

   // shadow allocator state
   int      shadow_mode;
   int      shadow_region;
   int      shadow_free;
   int      shadow_hcnt;
   int      hole_at[MAX_HOLES];
   int      hole_len[MAX_HOLES];
   int      grant_at[MAX_GRANTS];
   int      grant_len[MAX_GRANTS];
   int      grant_own[MAX_GRANTS];
   bit      grant_live[MAX_GRANTS];

   fit_policy_heap_allocator uut (.*);

   always #(HALF_PERIOD) clock = ~clock;

   //------------------------------------------------------------------
   // Shadow allocator
   //------------------------------------------------------------------
   function automatic void shadow_init();
      for (int i = 0; i < MAX_HOLES; i++) begin
         hole_at[i] = 0;
         hole_len[i] = 0;
      end
      for (int i = 0; i < MAX_GRANTS; i++) grant_live[i] = 1'b0;
      hole_len[0] = shadow_region;
      shadow_hcnt = 1;
      shadow_free = shadow_region;
   endfunction

   function automatic void hole_remove(int idx);
      for (int i = idx; i + 1 < shadow_hcnt; i++) begin
         hole_at[i] = hole_at[i + 1];
         hole_len[i] = hole_len[i + 1];
      end
      shadow_hcnt--;
   endfunction

   function automatic logic [1:0] shadow_alloc(int size, int owner, output int addr);
      int  slot;
      int  need;
      int  pick;
      bit  found;
      slot = -1;
      pick = 0;
      found = 1'b0;
      addr = 0;
      for (int i = 0; i < MAX_GRANTS; i++)
         if (!grant_live[i] && slot < 0) slot = i;
      if (slot < 0) return ST_FULL;
      need = (size + ALIGN - 1) & ~(ALIGN - 1);
      if (need == 0) need = ALIGN;
      // first fit stops at the first hole; best/worst keep the lowest on ties
      for (int i = 0; i < shadow_hcnt; i++) begin
         if (hole_len[i] >= need) begin
            if (!found) begin
               found = 1'b1;
               pick = i;
               if (shadow_mode != FIT_BEST && shadow_mode != FIT_WORST) break;
            end else if (shadow_mode == FIT_BEST && hole_len[i] < hole_len[pick]) begin
               pick = i;
            end else if (shadow_mode == FIT_WORST && hole_len[i] > hole_len[pick]) begin
               pick = i;
            end
         end
      end
      if (!found) return ST_NO_FIT;
      addr = hole_at[pick];
      if (hole_len[pick] == need) begin
         hole_remove(pick);
      end else begin
         hole_at[pick] += need;
         hole_len[pick] -= need;
      end
      shadow_free -= need;
      grant_live[slot] = 1'b1;
      grant_at[slot] = addr;
      grant_len[slot] = need;
      grant_own[slot] = owner;
      return ST_OK;
   endfunction

   function automatic logic [1:0] shadow_release(int addr, int owner);
      int g;
      int pos;
      int len;
      bit join_lo;
      bit join_hi;
      g = -1;
      pos = 0;
      for (int i = 0; i < MAX_GRANTS; i++)
         if (g < 0 && grant_live[i] && grant_at[i] == addr && grant_own[i] == owner) g = i;
      if (g < 0) return ST_NO_FOUND;
      len = grant_len[g];
      while (pos < shadow_hcnt && hole_at[pos] <= addr) pos++;
      join_lo = pos > 0 && hole_at[pos - 1] + hole_len[pos - 1] == addr;
      join_hi = pos < shadow_hcnt && addr + len == hole_at[pos];
      if (join_lo) begin
         hole_len[pos - 1] += len;
         if (join_hi) begin
            hole_len[pos - 1] += hole_len[pos];
            hole_remove(pos);
         end
      end else if (join_hi) begin
         hole_at[pos] = addr;
         hole_len[pos] += len;
      end else begin
         if (shadow_hcnt >= MAX_HOLES) return ST_FULL;
         for (int i = shadow_hcnt; i > pos; i--) begin
            hole_at[i] = hole_at[i - 1];
            hole_len[i] = hole_len[i - 1];
         end
         hole_at[pos] = addr;
         hole_len[pos] = len;
         shadow_hcnt++;
      end
      shadow_free += len;
      grant_live[g] = 1'b0;
      return ST_OK;
   endfunction

   // queue a transaction and its predicted response (issue order = accept order)
   function automatic void queue_req(logic op, int size, int addr, int owner);
      heap_req_type r;
      heap_rsp_type e;
      int        granted;
      r.op = op;
      r.size = size[15:0];
      r.addr = addr[15:0];
      r.owner = owner[7:0];
      granted = 0;
      if (op == OP_ALLOC) begin
         e.status = shadow_alloc(size & 16'hFFFF, owner & 8'hFF, granted);
         if (e.status != ST_OK) granted = 0;
      end else begin
         e.status = shadow_release(addr & 16'hFFFF, owner & 8'hFF);
      end
      e.granted = granted[15:0];
      e.free_b = shadow_free[15:0];
      e.used_b = 16'(shadow_region - shadow_free);
      pending_reqs.push_back(r);
      expected_rsps.push_back(e);
   endfunction

   // free of a live grant, sometimes with a corrupted owner or address, else a random free
   function automatic void queue_release_live();
      int live[$];
      int g;
      int owner;
      int addr;
      for (int i = 0; i < MAX_GRANTS; i++)
         if (grant_live[i]) live.push_back(i);
      if (live.size() == 0 || $urandom_range(0, 9) == 0) begin
         queue_req(OP_FREE, $urandom, $urandom, $urandom);
      end else begin
         g = live[$urandom_range(0, live.size() - 1)];
         owner = grant_own[g];
         addr = grant_at[g];
         if ($urandom_range(0, 9) == 0) owner ^= 1 << $urandom_range(0, 7);
         if ($urandom_range(0, 19) == 0) addr += 4;
         queue_req(OP_FREE, $urandom, addr, owner);
      end
   endfunction

   //------------------------------------------------------------------
   // Driver: bursts of random length, random gaps
   //------------------------------------------------------------------
   int burst_left = 0;
   int gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) void'(pending_reqs.pop_front());
         if (req_valid && req_stall) begin
            // hold the stalled transaction
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            req_valid <= 1'b1;
            req_operation <= pending_reqs[0].op;
            req_request_size <= pending_reqs[0].size;
            req_block_address <= pending_reqs[0].addr;
            req_owner_id <= pending_reqs[0].owner;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 12);
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // pending_reqs[0] stays presented until accepted; it is popped at the
   // accepting edge, before the next one is presented
   //------------------------------------------------------------------
   // Receiver stall pattern, with an occasional long hold-off
   //------------------------------------------------------------------
   int hold_cnt = 0;
   int stall_phase = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_cnt > 0) begin
         hold_cnt <= hold_cnt - 1;
         rsp_stall <= 1'b1;
      end else if (hold_served < hold_requests) begin
         hold_served <= hold_served + 1;
         hold_cnt <= LONG_HOLD;
         rsp_stall <= 1'b1;
      end else begin
         stall_phase <= stall_phase + 1;
         // alternate stretches of no stalling with randomly stalled stretches
         if ((stall_phase / 500) % 2 == 0) rsp_stall <= 1'b0;
         else rsp_stall <= ($urandom_range(0, 2) == 0);
      end
   end

   //------------------------------------------------------------------
   // Monitor / scoreboard
   //------------------------------------------------------------------
   task automatic report_mismatch(string what, int got, int want);
      $display("%0t mismatch on %s: got %0d expected %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      heap_rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected response", 1, 0);
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_status !== e.status) report_mismatch("status", rsp_status, e.status);
            if (rsp_granted_address !== e.granted)
               report_mismatch("granted_address", rsp_granted_address, e.granted);
            if (rsp_free_bytes !== e.free_b)
               report_mismatch("free_bytes", rsp_free_bytes, e.free_b);
            if (rsp_used_bytes !== e.used_b)
               report_mismatch("used_bytes", rsp_used_bytes, e.used_b);
         end
      end
   end

   //------------------------------------------------------------------
   // Stimulus
   //------------------------------------------------------------------
   task automatic wait_idle();
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic idx, logic [15:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_FIT_MODE) begin
         shadow_mode = value & 3;
      end else begin
         shadow_region = (value < 4) ? 4 : value;
         shadow_init();
      end
   endtask

   task automatic random_phase(int count, int max_size);
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(0, 19))
            0: queue_req(OP_ALLOC, $urandom, $urandom, $urandom);
            1: queue_req(OP_FREE, $urandom, $urandom, $urandom);
            2, 3, 4, 5, 6, 7, 8: queue_release_live();
            default: queue_req(OP_ALLOC, $urandom_range(0, max_size), $urandom, $urandom);
         endcase
      end
   endtask

   initial begin
      shadow_mode = FIT_FIRST;
      shadow_region = 16384;
      shadow_init();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: zero size, rounding, no fit, bad frees, grant table limit
      queue_req(OP_ALLOC, 0, 0, 1);
      queue_req(OP_ALLOC, 5, 0, 2);
      queue_req(OP_ALLOC, 4, 0, 3);
      queue_req(OP_ALLOC, 16'hFFFF, 16'hFFFF, 8'hFF);
      queue_req(OP_FREE, 0, 0, 9);
      queue_req(OP_FREE, 0, 16'hFFFF, 1);
      queue_req(OP_FREE, 0, 0, 1);
      queue_req(OP_FREE, 0, 0, 1);
      for (int i = 0; i < 15; i++) queue_req(OP_ALLOC, 8 + 4 * i, 0, i);
      for (int i = 0; i < 4; i++) queue_release_live();
      wait_idle();

      random_phase(PHASE_ITEMS, 700);
      wait_idle();

      // small region: no-fit and best fit; receiver holds off while sender pushes
      csr_write(CSR_FIT_MODE, FIT_BEST);
      csr_write(CSR_TOTAL, 16'd256);
      hold_requests++;
      random_phase(PHASE_ITEMS, 40);
      wait_idle();

      csr_write(CSR_FIT_MODE, FIT_WORST);
      csr_write(CSR_TOTAL, 16'hFFFF);
      random_phase(PHASE_ITEMS, 9000);
      wait_idle();

      // mode 3 behaves as first fit; region smaller than the minimum
      csr_write(CSR_FIT_MODE, 16'hFFFF);
      csr_write(CSR_TOTAL, 16'd0);
      random_phase(60, 8);
      wait_idle();
      csr_write(CSR_TOTAL, 16'd3);
      random_phase(40, 8);
      wait_idle();

      csr_write(CSR_FIT_MODE, FIT_BEST);
      csr_write(CSR_TOTAL, 16'd1024);
      hold_requests++;
      random_phase(PHASE_ITEMS, 120);
      wait_idle();

      csr_write(CSR_FIT_MODE, FIT_WORST);
      csr_write(CSR_TOTAL, 16'd600);
      random_phase(PHASE_ITEMS, 60);
      wait_idle();

      csr_write(CSR_FIT_MODE, 16'h0000);
      csr_write(CSR_TOTAL, 16'd4096);
      random_phase(PHASE_ITEMS, 300);
      wait_idle();

      if (mismatches == 0) $display("fit_policy_heap_allocator_tb: PASS");
      else $display("fit_policy_heap_allocator_tb: FAIL");
      $finish;
   end

   // watchdog
   initial begin
      #(2 * HALF_PERIOD * 3_000_000);
      $display("fit_policy_heap_allocator_tb: FAIL");
      $finish;
   end

endmodule
